@@ sv/analog_keypad_decode_repeat_core_macros.svh @@
// Assertion macros for the analog keypad decoder checker.
// Included by akdr_checker.sv; no other dependencies.
`ifndef ANALOG_KEYPAD_DECODE_REPEAT_CORE_MACROS_SVH
`define ANALOG_KEYPAD_DECODE_REPEAT_CORE_MACROS_SVH

// check a property outside reset
`define AKDR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define AKDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/akdr_pkg.sv @@
// Types and constants for the analog keypad decoder with auto-repeat.
// No dependencies; used by the core and its checker.
`timescale 1ns / 1ps
`default_nettype none

package akdr_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned KEY_W      = 3;
  localparam int unsigned IVL_W      = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TDATA_W  = 8;

  localparam logic [SAMPLE_W-1:0] MIN_IDLE = 10'd1023;

  localparam logic [IVL_W-1:0]    RST_REPEAT_INTERVAL = 15'd250;
  localparam logic [IVL_W-1:0]    RST_REPEAT_DELAY    = 15'd500;
  localparam logic [SAMPLE_W-1:0] RST_NONE_THR        = 10'd1000;
  localparam logic [SAMPLE_W-1:0] RST_SELECT_THR      = 10'd700;
  localparam logic [SAMPLE_W-1:0] RST_LEFT_THR        = 10'd450;
  localparam logic [SAMPLE_W-1:0] RST_DOWN_THR        = 10'd300;
  localparam logic [SAMPLE_W-1:0] RST_UP_THR          = 10'd100;

  typedef enum logic [KEY_W-1:0] {
    KEY_NONE    = 3'd0,
    KEY_RIGHT   = 3'd1,
    KEY_UP      = 3'd2,
    KEY_DOWN    = 3'd3,
    KEY_LEFT    = 3'd4,
    KEY_SELECT  = 3'd5,
    KEY_NOT_DUE = 3'd6
  } key_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPEAT_INTERVAL = 3'd0,
    REG_REPEAT_DELAY    = 3'd1,
    REG_NONE_THR        = 3'd2,
    REG_SELECT_THR      = 3'd3,
    REG_LEFT_THR        = 3'd4,
    REG_DOWN_THR        = 3'd5,
    REG_UP_THR          = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic [TIME_W-1:0]   now_ms;
  } item_t;

endpackage

`default_nettype wire

@@ sv/analog_keypad_decode_repeat_core.sv @@
// Analog keypad decoder: group minimum, threshold classification, auto-repeat.
// Depends on akdr_pkg.
//
// Input stream: s_axis_* carries one ADC sample with its millisecond timestamp;
// tlast closes a sample group. Every group close yields exactly one result
// transaction on m_axis_* (key code 0..6); other samples yield none.
// Configuration: cfg_valid_i/cfg_index_i/cfg_data_i write one register per
// transaction; cfg_ready_o is always high. Unknown indexes are dropped.
// Write configuration only while no transaction is in flight.
// Path: an accepted sample is held in the input register; from there it
// updates the running minimum and repeat state and, if it closes a group,
// loads the result register, which drives m_axis.
// Throughput: one sample per cycle except during a Stall (below); between the
// input and result registers: a 10-bit min, seven compares, a 32-bit subtract.
// Stall: while a result waits on m_axis_tready_i, samples not closing a group
// keep flowing; a closing sample holds in the input register until the result
// register frees, and s_axis_tready_o drops only then.
// Reset: thresholds and repeat timings return to defaults, running minimum to
// 1023, previous key to none, report time and repeat flag to zero.
`timescale 1ns / 1ps
`default_nettype none

module analog_keypad_decode_repeat_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output      logic                                s_axis_tready_o,
  // [9:0] sample, [41:10] now_ms, [47:42] zero
  input  wire logic [akdr_pkg::S_TDATA_W-1:0]      s_axis_tdata_i,
  input  wire logic                                s_axis_tlast_i,
  output      logic                                m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // [2:0] key, [7:3] zero
  output      logic [akdr_pkg::M_TDATA_W-1:0]      m_axis_tdata_o,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [akdr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [akdr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned SW = akdr_pkg::SAMPLE_W;
  localparam int unsigned TW = akdr_pkg::TIME_W;
  localparam int unsigned IW = akdr_pkg::IVL_W;

  // configuration registers
  logic [IW-1:0] repeat_interval_q, repeat_delay_q;
  logic [SW-1:0] none_thr_q, select_thr_q, left_thr_q, down_thr_q, up_thr_q;

  // input register
  logic            in_valid_q, in_valid_d;
  akdr_pkg::item_t in_item_q, in_item_d;

  // decoder state
  logic [SW-1:0]      run_min_q, run_min_d;
  akdr_pkg::key_e     prev_key_q, prev_key_d;
  logic [TW-1:0]      prev_time_q, prev_time_d;
  logic               has_rep_q, has_rep_d;

  // result register
  logic           out_valid_q, out_valid_d;
  akdr_pkg::key_e out_key_q, out_key_d;

  logic           out_free, advance, in_accept;
  logic [SW-1:0]  level;
  akdr_pkg::key_e cls_key, key;
  logic [TW-1:0]  elapsed;
  logic           not_due;

  assign cfg_ready_o     = 1'b1;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && (!in_item_q.last || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(akdr_pkg::M_TDATA_W - akdr_pkg::KEY_W){1'b0}}, out_key_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_interval_q <= akdr_pkg::RST_REPEAT_INTERVAL;
      repeat_delay_q    <= akdr_pkg::RST_REPEAT_DELAY;
      none_thr_q        <= akdr_pkg::RST_NONE_THR;
      select_thr_q      <= akdr_pkg::RST_SELECT_THR;
      left_thr_q        <= akdr_pkg::RST_LEFT_THR;
      down_thr_q        <= akdr_pkg::RST_DOWN_THR;
      up_thr_q          <= akdr_pkg::RST_UP_THR;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        akdr_pkg::REG_REPEAT_INTERVAL: repeat_interval_q <= cfg_data_i[IW-1:0];
        akdr_pkg::REG_REPEAT_DELAY:    repeat_delay_q    <= cfg_data_i[IW-1:0];
        akdr_pkg::REG_NONE_THR:        none_thr_q        <= cfg_data_i[SW-1:0];
        akdr_pkg::REG_SELECT_THR:      select_thr_q      <= cfg_data_i[SW-1:0];
        akdr_pkg::REG_LEFT_THR:        left_thr_q        <= cfg_data_i[SW-1:0];
        akdr_pkg::REG_DOWN_THR:        down_thr_q        <= cfg_data_i[SW-1:0];
        akdr_pkg::REG_UP_THR:          up_thr_q          <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    in_item_d  = in_item_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (in_accept) begin
      in_valid_d       = 1'b1;
      in_item_d.sample = s_axis_tdata_i[SW-1:0];
      in_item_d.last   = s_axis_tlast_i;
      in_item_d.now_ms = s_axis_tdata_i[SW+TW-1:SW];
    end
  end

  // minimum, classification, auto-repeat
  always_comb begin
    level = (in_item_q.sample < run_min_q) ? in_item_q.sample : run_min_q;

    if (level > none_thr_q) begin
      cls_key = akdr_pkg::KEY_NONE;
    end else if (level > select_thr_q) begin
      cls_key = akdr_pkg::KEY_SELECT;
    end else if (level > left_thr_q) begin
      cls_key = akdr_pkg::KEY_LEFT;
    end else if (level > down_thr_q) begin
      cls_key = akdr_pkg::KEY_DOWN;
    end else if (level > up_thr_q) begin
      cls_key = akdr_pkg::KEY_UP;
    end else begin
      cls_key = akdr_pkg::KEY_RIGHT;
    end

    elapsed = in_item_q.now_ms - prev_time_q;
    not_due = (elapsed < {{(TW-IW){1'b0}}, repeat_interval_q})
           || (!has_rep_q && (elapsed < {{(TW-IW){1'b0}}, repeat_delay_q}));

    run_min_d   = run_min_q;
    prev_key_d  = prev_key_q;
    prev_time_d = prev_time_q;
    has_rep_d   = has_rep_q;
    key         = cls_key;

    if (advance) begin
      if (!in_item_q.last) begin
        run_min_d = level;
      end else begin
        run_min_d = akdr_pkg::MIN_IDLE;
        if (cls_key == akdr_pkg::KEY_NONE) begin
          prev_key_d = akdr_pkg::KEY_NONE;
        end else if (cls_key == prev_key_q) begin
          if (not_due) begin
            key = akdr_pkg::KEY_NOT_DUE;
          end else begin
            has_rep_d   = 1'b1;
            prev_time_d = in_item_q.now_ms;
          end
        end else begin
          prev_key_d  = cls_key;
          has_rep_d   = 1'b0;
          prev_time_d = in_item_q.now_ms;
        end
      end
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_key_d   = out_key_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && in_item_q.last) begin
      out_valid_d = 1'b1;
      out_key_d   = key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      run_min_q   <= akdr_pkg::MIN_IDLE;
      prev_key_q  <= akdr_pkg::KEY_NONE;
      prev_time_q <= '0;
      has_rep_q   <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      run_min_q   <= run_min_d;
      prev_key_q  <= prev_key_d;
      prev_time_q <= prev_time_d;
      has_rep_q   <= has_rep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_item_q <= in_item_d;
    out_key_q <= out_key_d;
  end

endmodule

`default_nettype wire

@@ sv/akdr_checker.sv @@
// Port-level checker for analog_keypad_decode_repeat_core, bound into the core.
// Depends on akdr_pkg and analog_keypad_decode_repeat_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "analog_keypad_decode_repeat_core_macros.svh"

module akdr_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic [akdr_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  input wire logic                            cfg_ready_o
);

  `AKDR_ASSERT(a_key_code, clk_i, rst_ni, m_axis_tvalid_o |-> (m_axis_tdata_o[2:0] != 3'd7), "key code out of range")
  `AKDR_ASSERT(a_pad_zero, clk_i, rst_ni, m_axis_tvalid_o |-> (m_axis_tdata_o[7:3] == 5'd0), "result padding not zero")
  `AKDR_ASSERT(a_hold, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)), "stalled result changed")
  `AKDR_ASSERT_ALWAYS(a_cfg_ready, clk_i, cfg_ready_o, "configuration port not ready")
  `AKDR_ASSERT_ALWAYS(a_reset_quiet, clk_i, $rose(rst_ni) |-> !m_axis_tvalid_o, "result valid out of reset")

endmodule

bind analog_keypad_decode_repeat_core akdr_checker u_akdr_checker (.*);

`default_nettype wire

@@ bench/tb_analog_keypad_decode_repeat_core.sv @@
// Self-checking testbench for analog_keypad_decode_repeat_core: group minimum,
// threshold classification and auto-repeat timing, checked against a predictor.
// Depends on akdr_pkg and the core; needs no files or arguments.
`timescale 1ns / 1ps

import akdr_pkg::*;

class keypad_scoreboard;
  logic [IVL_W-1:0]    repeat_ivl;
  logic [IVL_W-1:0]    repeat_dly;
  logic [SAMPLE_W-1:0] thr_none;
  logic [SAMPLE_W-1:0] thr_select;
  logic [SAMPLE_W-1:0] thr_left;
  logic [SAMPLE_W-1:0] thr_down;
  logic [SAMPLE_W-1:0] thr_up;
  logic [SAMPLE_W-1:0] group_min;
  key_e                held_key;
  logic [TIME_W-1:0]   report_ms;
  bit                  repeated;
  key_e                expected_keys[$];
  int                  errors;

  function new();
    repeat_ivl  = RST_REPEAT_INTERVAL;
    repeat_dly  = RST_REPEAT_DELAY;
    thr_none    = RST_NONE_THR;
    thr_select  = RST_SELECT_THR;
    thr_left    = RST_LEFT_THR;
    thr_down    = RST_DOWN_THR;
    thr_up      = RST_UP_THR;
    group_min   = MIN_IDLE;
    held_key    = KEY_NONE;
    report_ms   = '0;
    repeated    = 1'b0;
    errors      = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_REPEAT_INTERVAL: repeat_ivl = data[IVL_W-1:0];
      REG_REPEAT_DELAY:    repeat_dly = data[IVL_W-1:0];
      REG_NONE_THR:        thr_none   = data[SAMPLE_W-1:0];
      REG_SELECT_THR:      thr_select = data[SAMPLE_W-1:0];
      REG_LEFT_THR:        thr_left   = data[SAMPLE_W-1:0];
      REG_DOWN_THR:        thr_down   = data[SAMPLE_W-1:0];
      REG_UP_THR:          thr_up     = data[SAMPLE_W-1:0];
      default: ;
    endcase
  endfunction

  function key_e classify(logic [SAMPLE_W-1:0] level);
    if (level > thr_none)   return KEY_NONE;
    if (level > thr_select) return KEY_SELECT;
    if (level > thr_left)   return KEY_LEFT;
    if (level > thr_down)   return KEY_DOWN;
    if (level > thr_up)     return KEY_UP;
    return KEY_RIGHT;
  endfunction

  function void note_sample(logic [SAMPLE_W-1:0] sample, logic last, logic [TIME_W-1:0] now);
    key_e              key;
    logic [TIME_W-1:0] elapsed;
    if (sample < group_min) group_min = sample;
    if (!last) return;
    key       = classify(group_min);
    group_min = MIN_IDLE;
    if (key == KEY_NONE) begin
      held_key = KEY_NONE;
    end else if (key == held_key) begin
      elapsed = now - report_ms;
      if (elapsed < repeat_ivl || (!repeated && elapsed < repeat_dly)) begin
        key = KEY_NOT_DUE;
      end else begin
        repeated  = 1'b1;
        report_ms = now;
      end
    end else begin
      held_key  = key;
      repeated  = 1'b0;
      report_ms = now;
    end
    expected_keys.push_back(key);
  endfunction

  task report_mismatch(string what);
    if (errors < 100) $display("[%0t] MISMATCH: %s", $realtime, what);
    errors++;
  endtask

  task check_key(logic [M_TDATA_W-1:0] tdata);
    key_e want;
    if (expected_keys.size() == 0) begin
      report_mismatch($sformatf("unexpected result key=%0d", tdata[KEY_W-1:0]));
      return;
    end
    want = expected_keys.pop_front();
    if (tdata[KEY_W-1:0] !== want)
      report_mismatch($sformatf("key got %0d want %0d", tdata[KEY_W-1:0], want));
    if (tdata[M_TDATA_W-1:KEY_W] !== '0)
      report_mismatch($sformatf("pad bits got %0h want 0", tdata[M_TDATA_W-1:KEY_W]));
  endtask

  function int pending();
    return expected_keys.size();
  endfunction
endclass

module tb_analog_keypad_decode_repeat_core;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int IDLE_LIMIT    = 5000;
  localparam int DRAIN_CYCLES  = 6;
  localparam int SEGMENT_ITEMS = 125;
  localparam int SEGMENTS      = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [S_TDATA_W-1:0]  s_axis_tdata_i;
  logic                  s_axis_tlast_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [M_TDATA_W-1:0]  m_axis_tdata_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int                sender_idle_pct;
  int                sink_stall_pct;
  int                items_sent;
  int                stuck_cycles;
  logic [TIME_W-1:0] clock_ms;
  keypad_scoreboard  sb;

  analog_keypad_decode_repeat_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_key(m_axis_tdata_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(logic [SAMPLE_W-1:0] sample, logic last,
                             logic [TIME_W-1:0] now);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(S_TDATA_W - SAMPLE_W - TIME_W){1'b0}}, now, sample};
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_sample(sample, last, now);
    items_sent++;
    @(negedge clk_i);
  endtask

  // One group whose minimum is exactly level.
  task automatic send_group(logic [SAMPLE_W-1:0] level, int count, logic [TIME_W-1:0] now);
    int low_pos;
    low_pos = $urandom_range(count - 1);
    for (int i = 0; i < count; i++) begin
      send_sample((i == low_pos) ? level : SAMPLE_W'($urandom_range(1023, level)),
                  i == count - 1, (i == count - 1) ? now : $urandom);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Thresholds carry random upper bits that the block must drop.
  function automatic logic [CFG_DATA_W-1:0] thr_word(int level);
    return {5'($urandom), 10'(level)};
  endfunction

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(int set);
    int up;
    int down;
    int left;
    int sel;
    up   = $urandom_range(200);
    down = up + $urandom_range(200);
    left = down + $urandom_range(200);
    sel  = left + $urandom_range(200);
    case (set)
      1: begin
        write_reg(REG_REPEAT_INTERVAL, 15'd0);
        write_reg(REG_REPEAT_DELAY, 15'd0);
        write_reg(REG_NONE_THR, thr_word($urandom_range(1023)));
        write_reg(REG_SELECT_THR, thr_word($urandom_range(1023)));
        write_reg(REG_LEFT_THR, thr_word($urandom_range(1023)));
        write_reg(REG_DOWN_THR, thr_word($urandom_range(1023)));
        write_reg(REG_UP_THR, thr_word($urandom_range(1023)));
      end
      2: begin
        write_reg(REG_REPEAT_INTERVAL, 15'h7FFF);
        write_reg(REG_REPEAT_DELAY, 15'h7FFF);
        write_reg(REG_NONE_THR, thr_word(1023));
        write_reg(REG_SELECT_THR, thr_word(900));
        write_reg(REG_LEFT_THR, thr_word(600));
        write_reg(REG_DOWN_THR, thr_word(300));
        write_reg(REG_UP_THR, thr_word(0));
      end
      3: begin
        write_reg(REG_REPEAT_INTERVAL, 15'($urandom_range(400)));
        write_reg(REG_REPEAT_DELAY, 15'($urandom_range(800)));
        write_reg(REG_NONE_THR, thr_word(sel + $urandom_range(200)));
        write_reg(REG_SELECT_THR, thr_word(sel));
        write_reg(REG_LEFT_THR, thr_word(left));
        write_reg(REG_DOWN_THR, thr_word(down));
        write_reg(REG_UP_THR, thr_word(up));
      end
      4: begin
        write_reg(REG_REPEAT_INTERVAL, 15'h7FFF);
        write_reg(REG_REPEAT_DELAY, 15'd0);
        write_reg(REG_NONE_THR, thr_word(0));
        write_reg(REG_SELECT_THR, thr_word(0));
        write_reg(REG_LEFT_THR, thr_word(0));
        write_reg(REG_DOWN_THR, thr_word(0));
        write_reg(REG_UP_THR, thr_word(0));
        write_reg(REG_UNUSED, 15'($urandom));
      end
      default: begin
        write_reg(REG_UNUSED, 15'($urandom));
        write_reg(REG_REPEAT_INTERVAL, 15'($urandom_range(600)));
        write_reg(REG_REPEAT_DELAY, 15'($urandom_range(1200)));
        write_reg(REG_NONE_THR, 15'($urandom));
        write_reg(REG_SELECT_THR, 15'($urandom));
        write_reg(REG_LEFT_THR, 15'($urandom));
        write_reg(REG_DOWN_THR, 15'($urandom));
        write_reg(REG_UP_THR, 15'($urandom));
      end
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // Aim at threshold edges a good part of the time.
  function automatic logic [SAMPLE_W-1:0] pick_level();
    int edge_val;
    case ($urandom_range(9))
      0: edge_val = sb.thr_none;
      1: edge_val = sb.thr_select;
      2: edge_val = sb.thr_left;
      3: edge_val = sb.thr_down;
      4: edge_val = sb.thr_up;
      default: return SAMPLE_W'($urandom);
    endcase
    edge_val = edge_val + int'($urandom_range(2)) - 1;
    if (edge_val < 0) edge_val = 0;
    if (edge_val > 1023) edge_val = 1023;
    return SAMPLE_W'(edge_val);
  endfunction

  function automatic logic [TIME_W-1:0] pick_step();
    int base;
    case ($urandom_range(4))
      0: return $urandom_range(50);
      1: base = sb.repeat_ivl;
      2: base = sb.repeat_dly;
      3: return $urandom_range(70000);
      default: return $urandom_range(2 * sb.repeat_dly + 2);
    endcase
    base = base + int'($urandom_range(2)) - 1;
    return (base < 0) ? '0 : TIME_W'(base);
  endfunction

  task automatic random_items(int count);
    int                  target;
    int                  holds;
    logic [SAMPLE_W-1:0] level;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(99) < 15) begin
        send_sample(SAMPLE_W'($urandom), 1'($urandom), $urandom);
      end else begin
        level = pick_level();
        holds = $urandom_range(1, 6);
        for (int i = 0; i < holds; i++) begin
          clock_ms = clock_ms + pick_step();
          send_group(level, $urandom_range(1, 4), clock_ms);
        end
      end
    end
  endtask

  task automatic set_idling(int mode);
    sender_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 70 : 0;
    sink_stall_pct  = (mode == 0) ? 70 : (mode == 1) ? 30 : 0;
  endtask

  initial begin
    sb = new();
    items_sent   = 0;
    clock_ms     = 32'hFFFF_0000;
    set_idling(0);
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Repeat timing of a held key, then every band edge, then a multi-sample
    // group and a held key across the timestamp wrap.
    send_sample(10'd0,    1'b1, 32'd1000);
    send_sample(10'd0,    1'b1, 32'd1010);
    send_sample(10'd100,  1'b1, 32'd1499);
    send_sample(10'd50,   1'b1, 32'd1500);
    send_sample(10'd10,   1'b1, 32'd1749);
    send_sample(10'd10,   1'b1, 32'd1750);
    send_sample(10'd1023, 1'b1, 32'd1760);
    send_sample(10'd101,  1'b1, 32'd1770);
    send_sample(10'd300,  1'b1, 32'd1780);
    send_sample(10'd301,  1'b1, 32'd1790);
    send_sample(10'd450,  1'b1, 32'd1800);
    send_sample(10'd451,  1'b1, 32'd1810);
    send_sample(10'd700,  1'b1, 32'd1820);
    send_sample(10'd701,  1'b1, 32'd1830);
    send_sample(10'd1000, 1'b1, 32'd1840);
    send_sample(10'd1001, 1'b1, 32'd1850);
    send_sample(10'd1023, 1'b0, 32'hFFFF_FFFF);
    send_sample(10'd600,  1'b0, 32'h5555_5555);
    send_sample(10'd200,  1'b0, 32'hAAAA_AAAA);
    send_sample(10'd900,  1'b1, 32'd1860);
    send_sample(10'd350,  1'b1, 32'hFFFF_FFF0);
    send_sample(10'd350,  1'b1, 32'h0000_0200);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg > 0) begin
        drain();
        configure(seg);
      end
      set_idling(seg / 2);
      random_items(SEGMENT_ITEMS);
    end
    drain();

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
